FILE: rtl/core/terminal_line_discipline_defines.svh
// Assertion macros for the terminal line discipline.
`ifndef TERMINAL_LINE_DISCIPLINE_DEFINES_SVH
`define TERMINAL_LINE_DISCIPLINE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define TLD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Two signals never high together.
`define TLD_ASSERT_EXCL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

FILE: rtl/core/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and constants of the terminal line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_TXDN  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BELL   = 2'd1,
    ST_OFULL  = 2'd2,
    ST_NOLINE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EXEC,
    FSM_OUT
  } fsm_e;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic lookup;    // registered memory reads in flight
    logic execute;   // commit state update and build result
    logic release_r; // result taken downstream
  } tld_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic result_valid;
  } tld_sts_t;

endpackage

FILE: rtl/core/tld_ram.sv
// ----------------------------------------------------------------------------
// tld_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tld_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/tld_ctrl.sv
// ----------------------------------------------------------------------------
// tld_ctrl
// Sequencer: accept, memory lookup, execute, hold result.
// ----------------------------------------------------------------------------
module tld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output tld_pkg::tld_cmd_t cmd_o,
  input  tld_pkg::tld_sts_t sts_i
);
  import tld_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = FSM_READ;
        end
      end
      FSM_READ: begin
        cmd_o.lookup = 1'b1;
        state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d = FSM_OUT;
      end
      FSM_OUT: begin
        out_valid_o = sts_i.result_valid;
        if (out_ready_i) begin
          cmd_o.release_r = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/tld_dp.sv
// ----------------------------------------------------------------------------
// tld_dp
// Queue pointers, per-terminal flags, queue memories and result register.
// ----------------------------------------------------------------------------
module tld_dp #(
  parameter int Terminals   = 4,
  parameter int InputDepth  = 1024,
  parameter int EchoDepth   = 1024,
  parameter int OutputDepth = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tld_pkg::tld_cmd_t cmd_i,
  output tld_pkg::tld_sts_t sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [1:0]        terminal_i,
  input  logic [7:0]        data_byte_i,
  output logic              tx_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              read_valid_o,
  output logic [7:0]        read_byte_o,
  output logic              read_line_end_o,
  output logic              line_ready_o,
  output logic              output_drained_o,
  output logic [1:0]        status_o
);
  import tld_pkg::*;

  localparam int TW = (Terminals > 1) ? $clog2(Terminals) : 1;
  localparam int IW = $clog2(InputDepth);
  localparam int EW = $clog2(EchoDepth);
  localparam int OW = $clog2(OutputDepth);

  // Per-terminal pointer and count registers.
  logic [IW-1:0] ih_q [Terminals];
  logic [IW-1:0] it_q [Terminals];
  logic [IW:0]   ic_q [Terminals];
  logic [EW-1:0] eh_q [Terminals];
  logic [EW-1:0] et_q [Terminals];
  logic [EW:0]   ec_q [Terminals];
  logic [OW-1:0] oh_q [Terminals];
  logic [OW-1:0] ot_q [Terminals];
  logic [OW:0]   oc_q [Terminals];
  logic [IW:0]   lc_q [Terminals];
  logic [Terminals-1:0] busy_q, plf_q;

  // Captured item.
  logic [1:0] op_q;
  logic [TW-1:0] t_q;
  logic [7:0] c_q;
  logic in_range_q;

  // Memory ports.
  logic ime_we, eme_we, ome_we;
  logic [TW+IW-1:0] ime_wa, ime_ra;
  logic [TW+EW-1:0] eme_wa, eme_ra;
  logic [TW+OW-1:0] ome_wa, ome_ra;
  logic [7:0] ime_wd, eme_wd, ome_wd, ime_rd, eme_rd, ome_rd;

  tld_ram #(.Width(8), .Depth(2 ** (TW + IW))) u_iram (
    .clk_i, .we_i(ime_we), .waddr_i(ime_wa), .wdata_i(ime_wd),
    .raddr_i(ime_ra), .rdata_o(ime_rd));
  tld_ram #(.Width(8), .Depth(2 ** (TW + EW))) u_eram (
    .clk_i, .we_i(eme_we), .waddr_i(eme_wa), .wdata_i(eme_wd),
    .raddr_i(eme_ra), .rdata_o(eme_rd));
  tld_ram #(.Width(8), .Depth(2 ** (TW + OW))) u_oram (
    .clk_i, .we_i(ome_we), .waddr_i(ome_wa), .wdata_i(ome_wd),
    .raddr_i(ome_ra), .rdata_o(ome_rd));

  // Current-terminal views.
  logic [IW-1:0] ih, it, it_m1;
  logic [IW:0]   ic, lc;
  logic [EW-1:0] eh, et;
  logic [EW:0]   ec;
  logic [OW-1:0] oh, ot, oh_m1;
  logic [OW:0]   oc;
  logic busy, plf;

  assign ih = ih_q[t_q];
  assign it = it_q[t_q];
  assign ic = ic_q[t_q];
  assign lc = lc_q[t_q];
  assign eh = eh_q[t_q];
  assign et = et_q[t_q];
  assign ec = ec_q[t_q];
  assign oh = oh_q[t_q];
  assign ot = ot_q[t_q];
  assign oc = oc_q[t_q];
  assign busy = busy_q[t_q];
  assign plf  = plf_q[t_q];
  assign it_m1 = (it == '0) ? IW'(InputDepth - 1) : it - 1'b1;
  assign oh_m1 = (oh == '0) ? OW'(OutputDepth - 1) : oh - 1'b1;

  // Read addresses: head of input (user read) or tail-1 (erase).
  always_comb begin
    ime_ra = {t_q, ih};
    if (op_q == OP_RX) ime_ra = {t_q, it_m1};
    eme_ra = {t_q, eh};
    ome_ra = {t_q, oh};
  end

  // Execute-stage combinational decision.
  logic [IW-1:0] ih_n, it_n;
  logic [IW:0]   ic_n, lc_n;
  logic [EW-1:0] eh_n, et_n;
  logic [EW:0]   ec_n;
  logic [OW-1:0] oh_n, ot_n;
  logic [OW:0]   oc_n;
  logic busy_n, plf_n;
  logic txv, rv, rle, drn;
  logic [7:0] txb, rb, ec_ch;
  logic [1:0] st;
  logic [7:0] seq1, seq2;
  logic [1:0] nseq;
  logic ok, is_crlf_in, is_erase_in;
  logic [EW:0] efree;
  logic [1:0] epush, npush;
  logic [EW-1:0] et_p1;

  assign is_crlf_in  = (c_q == CH_CR) || (c_q == CH_LF);
  assign is_erase_in = (c_q == CH_BS) || (c_q == CH_DEL);
  assign et_p1 = (et == EW'(EchoDepth - 1)) ? '0 : et + 1'b1;
  assign efree = (EW+1)'(EchoDepth) - ec;

  // Echo bytes past the first one of an item, written one per cycle.
  logic [1:0] epend_q;
  logic [7:0] eb1_q, eb2_q;

  always_comb begin
    ih_n = ih; it_n = it; ic_n = ic; lc_n = lc;
    eh_n = eh; et_n = et; ec_n = ec;
    oh_n = oh; ot_n = ot; oc_n = oc;
    busy_n = busy; plf_n = plf;
    txv = 1'b0; txb = '0; rv = 1'b0; rb = '0; rle = 1'b0; drn = 1'b0;
    st = ST_OK;
    ime_we = 1'b0; ime_wa = {t_q, it}; ime_wd = c_q;
    eme_we = 1'b0; eme_wa = {t_q, et}; eme_wd = '0;
    ome_we = 1'b0; ome_wa = {t_q, ot}; ome_wd = c_q;
    ok = 1'b0; ec_ch = c_q; seq1 = '0; seq2 = '0; nseq = 2'd1; epush = '0;
    npush = '0;
    case (op_q)
      OP_RX: begin
        if (is_erase_in) begin
          ok = (ic != '0);
          if (ok) begin
            it_n = it_m1;
            ic_n = ic - 1'b1;
            if (ime_rd == CH_LF && lc != '0) lc_n = lc - 1'b1;
          end
        end else begin
          ok = (ic < (IW+1)'(InputDepth));
          if (ok) begin
            ime_we = 1'b1;
            ime_wd = is_crlf_in ? CH_LF : c_q;
            it_n = (it == IW'(InputDepth - 1)) ? '0 : it + 1'b1;
            ic_n = ic + 1'b1;
            if (is_crlf_in) lc_n = lc + 1'b1;
          end
        end
        if (!ok) st = ST_BELL;
        ec_ch = ok ? c_q : CH_BEL;
        if (ec_ch == CH_CR || ec_ch == CH_LF) begin
          seq1 = CH_CR; seq2 = CH_LF; nseq = 2'd2;
        end else if (ec_ch == CH_BS || ec_ch == CH_DEL) begin
          seq1 = CH_BS; seq2 = CH_SP; nseq = 2'd3;
        end else begin
          seq1 = ec_ch; nseq = 2'd1;
        end
        // Bytes to enqueue: all of them if busy, else all but the first.
        if (!busy) begin
          txv = 1'b1; txb = seq1; busy_n = 1'b1;
          epush = nseq - 1'b1;
          eme_wd = seq2;
        end else begin
          epush = nseq;
          eme_wd = seq1;
        end
        // Bytes that find the echo queue full are dropped.
        npush = (efree < (EW+1)'(epush)) ? efree[1:0] : epush;
        if (npush != '0) begin
          eme_we = 1'b1;
          et_n = et_p1;
          ec_n = ec + 1'b1;
        end
      end
      OP_TXDN: begin
        drn = (oc == '0);
        if (ec != '0) begin
          txb = eme_rd; txv = 1'b1;
          eh_n = (eh == EW'(EchoDepth - 1)) ? '0 : eh + 1'b1;
          ec_n = ec - 1'b1;
        end else if (oc != '0) begin
          txv = 1'b1;
          if (ome_rd == CH_LF && !plf) begin
            plf_n = 1'b1; txb = CH_CR;
          end else begin
            oh_n = (oh == OW'(OutputDepth - 1)) ? '0 : oh + 1'b1;
            oc_n = oc - 1'b1;
            if (ome_rd == CH_LF) plf_n = 1'b0;
            txb = ome_rd;
          end
        end
        busy_n = txv;
      end
      OP_READ: begin
        if (lc == '0 || ic == '0) begin
          st = ST_NOLINE;
        end else begin
          rv = 1'b1; rb = ime_rd;
          ih_n = (ih == IW'(InputDepth - 1)) ? '0 : ih + 1'b1;
          ic_n = ic - 1'b1;
          if (ime_rd == CH_LF) begin
            rle = 1'b1; lc_n = lc - 1'b1;
          end
        end
      end
      default: begin
        if (!busy) begin
          if (c_q == CH_LF) begin
            if (oc < (OW+1)'(OutputDepth)) begin
              ome_we = 1'b1; ome_wa = {t_q, oh_m1}; ome_wd = CH_LF;
              oh_n = oh_m1; oc_n = oc + 1'b1;
              plf_n = 1'b1; txb = CH_CR; txv = 1'b1; busy_n = 1'b1;
            end else begin
              st = ST_OFULL;
            end
          end else begin
            txb = c_q; txv = 1'b1; busy_n = 1'b1;
          end
        end else if (oc < (OW+1)'(OutputDepth)) begin
          ome_we = 1'b1;
          ot_n = (ot == OW'(OutputDepth - 1)) ? '0 : ot + 1'b1;
          oc_n = oc + 1'b1;
        end else begin
          st = ST_OFULL;
        end
      end
    endcase
    if (!in_range_q || !cmd_i.execute) begin
      ime_we = 1'b0; eme_we = 1'b0; ome_we = 1'b0;
    end
    // Leftover echo bytes go in after execute, before the next beat can
    // reach its lookup.
    if (epend_q != '0) begin
      eme_we = 1'b1; eme_wa = {t_q, et}; eme_wd = eb1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Terminals; i++) begin
        ih_q[i] <= '0; it_q[i] <= '0; ic_q[i] <= '0; lc_q[i] <= '0;
        eh_q[i] <= '0; et_q[i] <= '0; ec_q[i] <= '0;
        oh_q[i] <= '0; ot_q[i] <= '0; oc_q[i] <= '0;
      end
      busy_q <= '0; plf_q <= '0;
      epend_q <= '0; eb1_q <= '0; eb2_q <= '0;
      sts_o.result_valid <= 1'b0;
      op_q <= '0; t_q <= '0; c_q <= '0; in_range_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        op_q <= opcode_i;
        t_q  <= TW'(terminal_i);
        c_q  <= data_byte_i;
        in_range_q <= (32'(terminal_i) < Terminals);
        sts_o.result_valid <= 1'b0;
      end
      if (cmd_i.execute) begin
        sts_o.result_valid <= 1'b1;
        if (in_range_q) begin
          ih_q[t_q] <= ih_n; it_q[t_q] <= it_n; ic_q[t_q] <= ic_n;
          lc_q[t_q] <= lc_n;
          eh_q[t_q] <= eh_n; et_q[t_q] <= et_n; ec_q[t_q] <= ec_n;
          oh_q[t_q] <= oh_n; ot_q[t_q] <= ot_n; oc_q[t_q] <= oc_n;
          busy_q[t_q] <= busy_n; plf_q[t_q] <= plf_n;
          if (op_q == OP_RX && npush > 2'd1) begin
            // Busy: SP BS or LF still to go; idle erase: trailing BS.
            epend_q <= npush - 2'd1;
            eb1_q   <= busy ? seq2 : CH_BS;
            eb2_q   <= CH_BS;
          end
        end
      end else if (epend_q != '0) begin
        epend_q   <= epend_q - 2'd1;
        eb1_q     <= eb2_q;
        et_q[t_q] <= et_p1;
        ec_q[t_q] <= ec + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (in_range_q) begin
        tx_valid_o       <= txv;
        tx_byte_o        <= txv ? txb : 8'h00;
        read_valid_o     <= rv;
        read_byte_o      <= rv ? rb : 8'h00;
        read_line_end_o  <= rle;
        line_ready_o     <= (lc_n != '0);
        output_drained_o <= drn;
        status_o         <= st;
      end else begin
        tx_valid_o <= 1'b0; tx_byte_o <= '0; read_valid_o <= 1'b0;
        read_byte_o <= '0; read_line_end_o <= 1'b0; line_ready_o <= 1'b0;
        output_drained_o <= 1'b0; status_o <= ST_OK;
      end
    end
  end
endmodule

FILE: rtl/core/terminal_line_discipline.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline
// Multi-terminal tty line discipline with echo and CR/LF handling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat per event:
//   received byte, transmit done, user read or user write, tagged with a
//   terminal number. Output channel (out_valid_o/out_ready_i) returns
//   exactly one result beat per input beat, in order.
//   The result beat is offered after the lookup state (registered memory
//   read) and the execute state that follow the accepting edge. The input
//   is not accepted again until the result is taken, so the block takes no
//   new item before it is through with the last; the read-modify-write of
//   the shared queue memories is the reason for this.
//   A received erase may queue up to three echo bytes, a CR/LF two; the
//   first is written at execute, the rest from the pending echo registers,
//   before the next beat can reach its lookup.
//   Reset clears all queue pointers, counts, line counts and transmit
//   flags; the queue memories are not cleared and never read unwritten.
//   A stalled receiver holds the result and blocks new input.
// ----------------------------------------------------------------------------
module terminal_line_discipline #(
  parameter int Terminals   = 4,
  parameter int InputDepth  = 1024,
  parameter int EchoDepth   = 1024,
  parameter int OutputDepth = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [1:0] terminal_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       read_line_end_o,
  output logic       line_ready_o,
  output logic       output_drained_o,
  output logic [1:0] status_o
);
  import tld_pkg::*;
  `include "terminal_line_discipline_defines.svh"

  tld_cmd_t cmd;
  tld_sts_t sts;

  tld_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .cmd_o(cmd), .sts_i(sts));

  tld_dp #(
    .Terminals(Terminals), .InputDepth(InputDepth),
    .EchoDepth(EchoDepth), .OutputDepth(OutputDepth)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .terminal_i, .data_byte_i,
    .tx_valid_o, .tx_byte_o, .read_valid_o, .read_byte_o, .read_line_end_o,
    .line_ready_o, .output_drained_o, .status_o);

  // A beat never enters while a result is still held.
  `TLD_ASSERT_EXCL(a_no_overlap, clk_i, rst_ni, in_ready_o, out_valid_o,
    "input accepted while result pending")
  // Read data only with a read success.
  `TLD_ASSERT(a_read_ok, clk_i, rst_ni,
    !out_valid_o || !read_valid_o || status_o == ST_OK,
    "read byte with error status")
  // Line end only on a read.
  `TLD_ASSERT(a_le_read, clk_i, rst_ni,
    !out_valid_o || !read_line_end_o || read_valid_o,
    "line end without read")
endmodule

FILE: tb/sv/tld_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tld_checker
// Watches both channels of the line discipline, predicts each result beat
// from the accepted input beats and compares it field by field.
// ----------------------------------------------------------------------------
module tld_checker
  import tld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [1:0] terminal_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_byte_i,
  input  logic       read_valid_i,
  input  logic [7:0] read_byte_i,
  input  logic       read_line_end_i,
  input  logic       line_ready_i,
  input  logic       output_drained_i,
  input  logic [1:0] status_i,
  output int         outstanding_o,
  output int         errors_o
);

  localparam int QueueDepth = 1024;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_line_end;
    logic       line_ready;
    logic       output_drained;
    status_e    status;
  } tld_result_t;

  // per-terminal state
  logic [7:0]  rx_line_q[4][$];
  logic [7:0]  echo_q[4][$];
  logic [7:0]  tx_out_q[4][$];
  int          lines_waiting[4];
  logic        xmit_busy[4];
  logic        lf_half_sent[4];
  tld_result_t expected_results[$];
  int          errors;

  assign outstanding_o = expected_results.size();
  assign errors_o      = errors;

  initial begin
    errors = 0;
    for (int i = 0; i < 4; i++) begin
      lines_waiting[i] = 0;
      xmit_busy[i]     = 1'b0;
      lf_half_sent[i]  = 1'b0;
    end
  end

  function automatic void queue_echo(input int t, input logic [7:0] b);
    if (echo_q[t].size() < QueueDepth) echo_q[t].push_back(b);
  endfunction

  // echo one character: first byte direct to transmitter when idle, else all queued
  function automatic void echo_char(input int t, input logic [7:0] c, inout tld_result_t r);
    logic [7:0] seq[3];
    int n;
    if (c == CH_CR || c == CH_LF) begin
      seq[0] = CH_CR; seq[1] = CH_LF; n = 2;
    end else if (c == CH_BS || c == CH_DEL) begin
      seq[0] = CH_BS; seq[1] = CH_SP; seq[2] = CH_BS; n = 3;
    end else begin
      seq[0] = c; n = 1;
    end
    if (!xmit_busy[t]) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = seq[0];
      for (int i = 1; i < n; i++) queue_echo(t, seq[i]);
      xmit_busy[t] = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) queue_echo(t, seq[i]);
    end
  endfunction

  function automatic tld_result_t discipline_step(input op_e op, input int t,
                                                  input logic [7:0] c);
    tld_result_t r;
    logic ok;
    logic [7:0] b;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_RX: begin
        if (c == CH_CR || c == CH_LF) begin
          ok = rx_line_q[t].size() < QueueDepth;
          if (ok) begin
            rx_line_q[t].push_back(CH_LF);
            lines_waiting[t]++;
          end
        end else if (c == CH_BS || c == CH_DEL) begin
          ok = rx_line_q[t].size() > 0;
          if (ok) begin
            b = rx_line_q[t].pop_back();
            if (b == CH_LF && lines_waiting[t] > 0) lines_waiting[t]--;
          end
        end else begin
          ok = rx_line_q[t].size() < QueueDepth;
          if (ok) rx_line_q[t].push_back(c);
        end
        if (!ok) r.status = ST_BELL;
        echo_char(t, ok ? c : CH_BEL, r);
      end
      OP_TXDN: begin
        r.output_drained = tx_out_q[t].size() == 0;
        if (echo_q[t].size() > 0) begin
          r.tx_byte  = echo_q[t].pop_front();
          r.tx_valid = 1'b1;
        end else if (tx_out_q[t].size() > 0) begin
          b = tx_out_q[t][0];
          if (b == CH_LF && !lf_half_sent[t]) begin
            // CR half of an output newline; LF stays queued
            lf_half_sent[t] = 1'b1;
            r.tx_byte = CH_CR;
          end else begin
            void'(tx_out_q[t].pop_front());
            if (b == CH_LF) lf_half_sent[t] = 1'b0;
            r.tx_byte = b;
          end
          r.tx_valid = 1'b1;
        end else begin
          xmit_busy[t] = 1'b0;
        end
        if (r.tx_valid) xmit_busy[t] = 1'b1;
      end
      OP_READ: begin
        if (lines_waiting[t] == 0 || rx_line_q[t].size() == 0) begin
          r.status = ST_NOLINE;
        end else begin
          r.read_byte  = rx_line_q[t].pop_front();
          r.read_valid = 1'b1;
          if (r.read_byte == CH_LF) begin
            r.read_line_end = 1'b1;
            lines_waiting[t]--;
          end
        end
      end
      default: begin
        if (!xmit_busy[t]) begin
          if (c == CH_LF) begin
            if (tx_out_q[t].size() < QueueDepth) begin
              tx_out_q[t].push_front(CH_LF);
              lf_half_sent[t] = 1'b1;
              r.tx_byte  = CH_CR;
              r.tx_valid = 1'b1;
              xmit_busy[t] = 1'b1;
            end else begin
              r.status = ST_OFULL;
            end
          end else begin
            r.tx_byte  = c;
            r.tx_valid = 1'b1;
            xmit_busy[t] = 1'b1;
          end
        end else if (tx_out_q[t].size() < QueueDepth) begin
          tx_out_q[t].push_back(c);
        end else begin
          r.status = ST_OFULL;
        end
      end
    endcase
    r.line_ready = lines_waiting[t] > 0;
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    tld_result_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("tx_valid", e.tx_valid, tx_valid_i);
          check_field("tx_byte", e.tx_byte, tx_byte_i);
          check_field("read_valid", e.read_valid, read_valid_i);
          check_field("read_byte", e.read_byte, read_byte_i);
          check_field("read_line_end", e.read_line_end, read_line_end_i);
          check_field("line_ready", e.line_ready, line_ready_i);
          check_field("output_drained", e.output_drained, output_drained_i);
          check_field("status", e.status, status_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(discipline_step(op_e'(opcode_i), int'(terminal_i),
                                                   data_byte_i));
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the terminal line discipline: directed beats for
// the echo, erase, newline and empty cases, short back-to-back bursts, then
// weighted random traffic with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import tld_pkg::*;

  localparam int IdleLimit = 5000; // cycles with no beat before giving up

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] opcode = '0;
  logic [1:0] terminal = '0;
  logic [7:0] data_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       tx_valid, read_valid, read_line_end, line_ready, output_drained;
  logic [7:0] tx_byte, read_byte;
  logic [1:0] status;
  int         outstanding, errors;
  int         results_taken = 0;
  int         idle_cycles = 0;
  logic       no_gaps = 1'b0; // stretches with neither side idling

  always #2 clk_i = ~clk_i;

  terminal_line_discipline i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .terminal_i(terminal), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .tx_valid_o(tx_valid), .tx_byte_o(tx_byte),
    .read_valid_o(read_valid), .read_byte_o(read_byte),
    .read_line_end_o(read_line_end), .line_ready_o(line_ready),
    .output_drained_o(output_drained), .status_o(status)
  );

  tld_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .terminal_i(terminal), .data_byte_i(data_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .tx_valid_i(tx_valid), .tx_byte_i(tx_byte),
    .read_valid_i(read_valid), .read_byte_i(read_byte),
    .read_line_end_i(read_line_end), .line_ready_i(line_ready),
    .output_drained_i(output_drained), .status_i(status),
    .outstanding_o(outstanding), .errors_o(errors)
  );

  // Offer one beat, after a random gap, and hold it until accepted.
  task automatic send_beat(input op_e op, input logic [1:0] term, input logic [7:0] d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    terminal  <= term;
    data_byte <= d;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Mostly typing: text, line ends and erases; now and then any byte.
  function automatic logic [7:0] typed_char();
    case ($urandom_range(0, 9))
      5: return CH_CR;
      6: return CH_LF;
      7: return CH_BS;
      8: return CH_DEL;
      9: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready gaps, one long hold-off so the block backs up.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (results_taken == 150) stall = 80;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      results_taken++;
    end
  end

  // Watchdog on beats in either direction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: line entry, reads, erase cases, echo drain, output newline.
    send_beat(OP_RX, 2'd0, 8'h68);
    send_beat(OP_RX, 2'd0, CH_CR);
    send_beat(OP_READ, 2'd0, 8'h00);
    send_beat(OP_READ, 2'd0, 8'h00);
    send_beat(OP_READ, 2'd0, 8'h00);          // no line left
    send_beat(OP_RX, 2'd0, CH_BS);            // erase on empty queue
    send_beat(OP_RX, 2'd0, CH_LF);
    send_beat(OP_RX, 2'd0, CH_DEL);           // erases the queued LF
    repeat (6) send_beat(OP_TXDN, 2'd0, 8'h00);
    send_beat(OP_WRITE, 2'd1, CH_LF);         // idle transmitter: CR now
    send_beat(OP_WRITE, 2'd1, 8'hFF);
    send_beat(OP_WRITE, 2'd1, CH_LF);         // busy: queued LF
    send_beat(OP_WRITE, 2'd1, 8'h00);
    repeat (6) send_beat(OP_TXDN, 2'd1, 8'h00);
    pause_until_drained();

    // Bursts: busy echo of erases on terminal 3, queued writes on terminal 2.
    no_gaps = 1'b1;
    repeat (30) send_beat(OP_RX, 2'd3, 8'h61);
    repeat (4) send_beat(OP_RX, 2'd3, CH_DEL);
    send_beat(OP_RX, 2'd3, CH_CR);
    repeat (30) send_beat(OP_WRITE, 2'd2, 8'h78);
    send_beat(OP_WRITE, 2'd2, CH_LF);
    no_gaps = 1'b0;

    // Random traffic, alternating gappy and back-to-back stretches.
    for (int i = 0; i < 420; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == 300) pause_until_drained();
      r = $urandom_range(0, 99);
      if (r < 45)      send_beat(OP_RX, 2'($urandom_range(0, 3)), typed_char());
      else if (r < 70) send_beat(OP_TXDN, 2'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)));
      else if (r < 85) send_beat(OP_READ, 2'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)));
      else             send_beat(OP_WRITE, 2'($urandom_range(0, 3)),
                                 ($urandom_range(0, 4) == 0) ? CH_LF :
                                 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
